@@ sv/polygon_perimeter_filter_top_macros.svh @@
// Assertion macros shared by the polygon perimeter filter modules.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef POLYGON_PERIMETER_FILTER_TOP_MACROS_SVH
`define POLYGON_PERIMETER_FILTER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPF_ASSERT_IMP(lbl, ante, cons, msg)
`define PPF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/ppf_pkg.sv @@
`default_nettype none

package ppf_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int PERIM_WIDTH   = 40;
    localparam int COUNT_WIDTH   = 16;
    localparam int SUM_WIDTH_DEF = 40;
    localparam int ROOT_WIDTH    = COORD_WIDTH + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic                          last_vertex;
    } t_in_req;

    typedef struct packed {
        logic [PERIM_WIDTH-1:0] perimeter;
        logic                   keep;
        logic [COUNT_WIDTH-1:0] vertex_total;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_SQ,
        S_INIT,
        S_ROOT,
        S_ACC,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic open_poly;
        logic use_first;
        logic square;
        logic start_root;
        logic root_step;
        logic accum;
        logic advance;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic cur_last;
        logic root_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/ppf_dp.sv @@
`default_nettype none

`include "polygon_perimeter_filter_top_macros.svh"

module ppf_dp import ppf_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_in_req                i_in_data,
    input  wire logic                   i_cfg_valid,
    input  wire logic [PERIM_WIDTH-1:0] i_cfg_data,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_req                    o_out_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * CW;
    localparam int RADW = 2 * ROOT_WIDTH;
    localparam int REMW = ROOT_WIDTH + 3;
    localparam int ITW  = $clog2(ROOT_WIDTH);
    localparam int CMPW = (SUM_WIDTH > PERIM_WIDTH) ? SUM_WIDTH : PERIM_WIDTH;

    localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};
    localparam logic [PERIM_WIDTH-1:0] PERIM_MAX = {PERIM_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic signed [CW-1:0]   r_first_x, r_first_y, r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic                   r_cur_last;
    logic [SUM_WIDTH-1:0]   r_sum;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [SQW-1:0]         r_sq_x, r_sq_y;
    logic [RADW-1:0]        r_rad;
    logic [REMW-1:0]        r_rem;
    logic [ROOT_WIDTH-1:0]  r_root;
    logic [ITW-1:0]         r_iter;
    logic [PERIM_WIDTH-1:0] r_min;
    logic                   r_out_valid;
    t_out_req               r_out;

    logic signed [CW-1:0]   oth_x, oth_y;
    logic signed [DW-1:0]   diff_x, diff_y;
    logic [DW-1:0]          abs_x, abs_y;
    logic [CW-1:0]          mag_x, mag_y;
    logic [SQW-1:0]         sq_x, sq_y;
    logic [REMW-1:0]        rem_sh, trial;
    logic [SUM_WIDTH:0]     sum_add;
    logic [CMPW-1:0]        sum_ext;
    logic [PERIM_WIDTH-1:0] perim;
    logic                   keep;

    // Edge vector magnitudes; the closing edge runs back to the first vertex.
    assign oth_x  = i_cmd.use_first ? r_first_x : r_prev_x;
    assign oth_y  = i_cmd.use_first ? r_first_y : r_prev_y;
    assign diff_x = $signed({r_cur_x[CW-1], r_cur_x}) - $signed({oth_x[CW-1], oth_x});
    assign diff_y = $signed({r_cur_y[CW-1], r_cur_y}) - $signed({oth_y[CW-1], oth_y});
    assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    assign mag_x  = abs_x[CW-1:0];
    assign mag_y  = abs_y[CW-1:0];
    assign sq_x   = SQW'(mag_x) * SQW'(mag_x);
    assign sq_y   = SQW'(mag_y) * SQW'(mag_y);

    // One restoring square root step: two radicand bits in, one root bit out.
    assign rem_sh = {r_rem[REMW-3:0], r_rad[RADW-1 -: 2]};
    assign trial  = REMW'({r_root, 2'b01});

    assign sum_add = {1'b0, r_sum} + (SUM_WIDTH+1)'(r_root);

    assign sum_ext = CMPW'(r_sum);
    assign perim   = (sum_ext > CMPW'(PERIM_MAX)) ? PERIM_MAX : sum_ext[PERIM_WIDTH-1:0];
    assign keep    = (sum_ext >= CMPW'(r_min));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x    <= i_in_data.x_coord;
            r_cur_y    <= i_in_data.y_coord;
            r_cur_last <= i_in_data.last_vertex;
        end
        if (i_cmd.open_poly) begin
            r_first_x <= r_cur_x;
            r_first_y <= r_cur_y;
            r_prev_x  <= r_cur_x;
            r_prev_y  <= r_cur_y;
            r_sum     <= '0;
        end
        if (i_cmd.advance) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.accum) begin
            r_sum <= sum_add[SUM_WIDTH] ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
        end
        if (i_cmd.square) begin
            r_sq_x <= sq_x;
            r_sq_y <= sq_y;
        end
        if (i_cmd.start_root) begin
            r_rad  <= RADW'(r_sq_x) + RADW'(r_sq_y);
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[RADW-3:0], 2'b00};
            r_iter <= r_iter + ITW'(1);
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_WIDTH-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_WIDTH-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out.perimeter    <= perim;
            r_out.keep         <= keep;
            r_out.vertex_total <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            if (i_cmd.open_poly) begin
                r_cnt <= COUNT_WIDTH'(1);
            end else if (i_cmd.advance && (r_cnt != COUNT_MAX)) begin
                r_cnt <= r_cnt + COUNT_WIDTH'(1);
            end else if (i_cmd.emit) begin
                r_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.cur_last  = r_cur_last;
        o_stat.root_done = (r_iter == ITW'(ROOT_WIDTH - 1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PPF_ASSERT_IMP(a_emit_room, i_cmd.emit, (!r_out_valid || i_out_ready), "emit over a full output register")
    `PPF_ASSERT_NXT(a_emit_closes, i_cmd.emit, (r_cnt == '0), "polygon still open after emit")

endmodule

`default_nettype wire

@@ sv/ppf_ctrl.sv @@
`default_nettype none

`include "polygon_perimeter_filter_top_macros.svh"

module ppf_ctrl import ppf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_closing, n_closing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_closing <= n_closing;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_closing  = r_closing;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.cnt_zero ? S_OPEN : S_SQ;
                end
            end
            S_OPEN: begin
                o_cmd.open_poly = 1'b1;
                n_state         = i_stat.cur_last ? S_EMIT : S_IDLE;
            end
            S_SQ: begin
                o_cmd.square    = 1'b1;
                o_cmd.use_first = r_closing;
                n_state         = S_INIT;
            end
            S_INIT: begin
                o_cmd.start_root = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                if (r_closing) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    if (i_stat.cur_last) begin
                        n_closing = 1'b1;
                        n_state   = S_SQ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_closing  = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state   = S_IDLE;
                n_closing = 1'b0;
            end
        endcase
    end

    `PPF_ASSERT_IMP(a_closing_last, r_closing, i_stat.cur_last, "closing edge on a vertex not flagged last")
    `PPF_ASSERT_IMP(a_acc_after_root, (r_state == S_ACC), ($past(r_state) == S_ROOT), "accumulate without a finished root")

endmodule

`default_nettype wire

@@ sv/polygon_perimeter_filter_top.sv @@
// Polygon perimeter filter.
// Vertex requests arrive on the input channel (i_in_valid / o_in_ready), one signed Q16.8
// x,y pair each, with last_vertex set on the final vertex of a closed polygon. For every
// polygon one result request leaves on the output channel (o_out_valid / i_out_ready):
// the closed perimeter in unsigned Q32.8, saturated, the keep flag, and the vertex count.
// The minimum perimeter is written through the configuration channel (i_cfg_valid /
// o_cfg_ready), which is always ready; write it only while no polygon is in flight.
// A vertex that opens a polygon is taken from the input channel and stored as the first
// vertex. Each further vertex is taken, then passes the edge length unit: the squares,
// their sum and the restoring square root, one root bit per cycle; its edge length is then
// accumulated. A last vertex runs the unit a second time for the closing edge, and then
// its result is registered in the output register; a single-vertex polygon goes there
// straight after it is opened.
// The result sits in an output register, so new vertex requests are accepted while it
// waits; only a later polygon's result stalls, holding the block until the receiver
// takes the pending one. Synchronous reset clears the open polygon, the output valid
// flag and the minimum perimeter.

`default_nettype none

module polygon_perimeter_filter_top import ppf_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_req                i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_req                    o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [PERIM_WIDTH-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The register write never stalls.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each vertex through the edge length unit.
    ppf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the vertices, running sum, square root unit and output register.
    ppf_dp #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_polygon_perimeter_filter_top.sv @@
`default_nettype none

module tb_polygon_perimeter_filter_top;
    import ppf_pkg::*;

    // Saturation limits of the running sum and of the perimeter field.
    localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_WIDTH_DEF) - 64'd1;
    localparam logic [63:0] PERIM_LIMIT = (64'd1 << PERIM_WIDTH) - 64'd1;
    localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 24'sh7FFFFF;

    // One unit in Q16.8, used to build shapes with exact edge lengths.
    localparam int UNIT = 256;

    // Cycles allowed for a closing vertex to finish before the block counts as idle.
    localparam int DRAIN_CYCLES = 64;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_req                i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_req               o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [PERIM_WIDTH-1:0] i_cfg_data;

    polygon_perimeter_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block's state, advanced once per accepted vertex request.
    t_in_req          poly_first;
    t_in_req          poly_prev;
    logic [63:0]      poly_sum   = '0;
    logic [15:0]      poly_count = '0;
    logic [PERIM_WIDTH-1:0] min_perim = '0;

    // Results predicted but not yet seen on the output channel, oldest first.
    t_out_req expected_polys[$];

    int errors     = 0;
    int burst_left = 0;
    int gap_max    = 0;
    int rx_run     = 0;
    int vertices_sent = 0;

    // Floor of the Euclidean distance between two vertices. The squared distance
    // carries twice the fraction bits, so the root keeps the Q16.8 scale.
    function automatic logic [63:0] edge_length(input logic signed [COORD_WIDTH-1:0] ax,
                                                input logic signed [COORD_WIDTH-1:0] ay,
                                                input logic signed [COORD_WIDTH-1:0] bx,
                                                input logic signed [COORD_WIDTH-1:0] by);
        longint      dx;
        longint      dy;
        logic [63:0] sq;
        logic [63:0] trial;
        logic [31:0] root;
        int          b;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq   = 64'(dx * dx + dy * dy);
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= sq) root = trial[31:0];
        end
        return {32'd0, root};
    endfunction

    task automatic add_edge(input logic [63:0] len);
        if (poly_sum > SUM_LIMIT) poly_sum = SUM_LIMIT;
        if (len > SUM_LIMIT - poly_sum) begin
            poly_sum = SUM_LIMIT;
        end else begin
            poly_sum = poly_sum + len;
        end
    endtask

    // Advances the shadow state by one vertex and queues the result of a closing vertex.
    task automatic account_vertex(input t_in_req v);
        t_out_req res;
        if (poly_count == 0) begin
            poly_first = v;
            poly_sum   = '0;
            poly_count = 16'd1;
        end else begin
            add_edge(edge_length(poly_prev.x_coord, poly_prev.y_coord, v.x_coord, v.y_coord));
            if (poly_count < COUNT_LIMIT) poly_count++;
        end
        poly_prev = v;
        if (v.last_vertex) begin
            add_edge(edge_length(v.x_coord, v.y_coord, poly_first.x_coord, poly_first.y_coord));
            res.perimeter    = (poly_sum > PERIM_LIMIT) ? PERIM_LIMIT[PERIM_WIDTH-1:0]
                                                        : poly_sum[PERIM_WIDTH-1:0];
            res.keep         = (poly_sum >= {24'd0, min_perim});
            res.vertex_total = poly_count;
            expected_polys.push_back(res);
            poly_count = '0;
        end
    endtask

    // Sends one vertex request. The sender runs in bursts; between bursts valid
    // drops for a random number of cycles unless gap_max is zero.
    task automatic send_vertex(input logic signed [COORD_WIDTH-1:0] x,
                               input logic signed [COORD_WIDTH-1:0] y,
                               input logic last);
        t_in_req v;
        v.x_coord     = x;
        v.y_coord     = y;
        v.last_vertex = last;
        if (burst_left == 0) begin
            if (gap_max > 0) repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_data  = v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        account_vertex(v);
        vertices_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Waits until every predicted result has come out, then lets a closing vertex
    // that is still in flight finish before the block is treated as idle.
    task automatic settle();
        while (expected_polys.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the minimum perimeter; callers make sure the block is idle first.
    task automatic write_min_perimeter(input logic [PERIM_WIDTH-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        min_perim = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return -24'sd1;
            default: return 24'sd1;
        endcase
    endfunction

    // A single vertex flagged last opens and closes a polygon: perimeter zero, count one.
    task automatic test_single_vertex();
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        send_vertex('0, '0, 1'b1);
    endtask

    // A triangle at the corners of the coordinate range, a degenerate two-vertex polygon
    // whose edges have zero length, and a small triangle near the origin.
    task automatic test_closed_shapes();
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(24'(-3 * UNIT), 24'(-4 * UNIT), 1'b0);
        send_vertex('0, '0, 1'b0);
        send_vertex(-24'sd1, 24'sd1, 1'b1);
    endtask

    // A unit square has a perimeter of exactly four units, so the keep flag can be
    // checked right at the threshold and one step above it.
    task automatic send_unit_square();
        send_vertex('0, '0, 1'b0);
        send_vertex(24'(UNIT), '0, 1'b0);
        send_vertex(24'(UNIT), 24'(UNIT), 1'b0);
        send_vertex('0, 24'(UNIT), 1'b1);
    endtask

    task automatic test_keep_threshold();
        settle();
        write_min_perimeter(40'(4 * UNIT));
        send_unit_square();
        settle();
        write_min_perimeter(40'(4 * UNIT + 1));
        send_unit_square();
        settle();
        write_min_perimeter('0);
        send_unit_square();
    endtask

    // One polygon that bounces between opposite corners, so every edge has the
    // largest length, sent back to back. With the threshold at its maximum the
    // perimeter is not kept.
    task automatic test_long_polygon();
        int i;
        settle();
        write_min_perimeter('1);
        gap_max = 0;
        for (i = 0; i < 64; i++) begin
            if (i % 2 == 0) begin
                send_vertex(COORD_MIN, COORD_MIN, i == 63);
            end else begin
                send_vertex(COORD_MAX, COORD_MAX, i == 63);
            end
        end
    endtask

    // Sends one polygon of n vertices. Styles: full-range noise, corner values, and a
    // local walk with small steps and repeated vertices.
    task automatic send_polygon(input int n, input int style);
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        int i;
        int step;
        cx = COORD_WIDTH'($urandom);
        cy = COORD_WIDTH'($urandom);
        for (i = 0; i < n; i++) begin
            case (style)
                0: begin
                    cx = COORD_WIDTH'($urandom);
                    cy = COORD_WIDTH'($urandom);
                end
                1: begin
                    cx = pick_corner();
                    cy = pick_corner();
                end
                default: begin
                    if ($urandom_range(0, 4) != 0) begin
                        step = $urandom_range(0, 1 << $urandom_range(0, 14));
                        cx = $urandom_range(0, 1) ? cx + 24'(step) : cx - 24'(step);
                        step = $urandom_range(0, 1 << $urandom_range(0, 14));
                        cy = $urandom_range(0, 1) ? cy + 24'(step) : cy - 24'(step);
                    end
                end
            endcase
            if ($urandom_range(0, 9) == 0) cx = COORD_WIDTH'($urandom);
            send_vertex(cx, cy, i == n - 1);
        end
    endtask

    // Random polygons in four phases, each with its own threshold and sender pacing.
    task automatic test_random_polygons();
        int phase;
        int quota;
        int n;
        int pick;
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0:       write_min_perimeter('0);
                1:       write_min_perimeter('1);
                2:       write_min_perimeter(40'($urandom_range(0, 1 << 28)));
                default: write_min_perimeter(40'($urandom_range(0, 1 << 16)));
            endcase
            gap_max = (phase == 1) ? 0 : $urandom_range(2, 30);
            quota   = vertices_sent + 240;
            while (vertices_sent < quota) begin
                pick = $urandom_range(0, 19);
                if (pick < 6) begin
                    n = $urandom_range(1, 3);
                end else if (pick < 17) begin
                    n = $urandom_range(4, 12);
                end else begin
                    n = $urandom_range(13, 60);
                end
                send_polygon(n, $urandom_range(0, 2));
            end
        end
    endtask

    // Receiver: ready runs high and low for random lengths, with occasional long
    // stretches of no stalls and occasional long stalls.
    always @(negedge i_clk) begin
        if (rx_run > 0) begin
            rx_run--;
        end else if (i_out_ready) begin
            i_out_ready = 1'b0;
            rx_run = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
        end else begin
            i_out_ready = 1'b1;
            rx_run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 15);
        end
    end

    // Every result request taken by the receiver is checked against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_polys.size() == 0) begin
                $display("%0t: unexpected result, got perimeter %0d keep %0b count %0d",
                         $time, o_out_data.perimeter, o_out_data.keep,
                         o_out_data.vertex_total);
                errors++;
            end else begin
                want = expected_polys.pop_front();
                if (o_out_data.perimeter !== want.perimeter) begin
                    $display("%0t: perimeter expected %0d, got %0d",
                             $time, want.perimeter, o_out_data.perimeter);
                    errors++;
                end
                if (o_out_data.keep !== want.keep) begin
                    $display("%0t: keep expected %0b, got %0b",
                             $time, want.keep, o_out_data.keep);
                    errors++;
                end
                if (o_out_data.vertex_total !== want.vertex_total) begin
                    $display("%0t: vertex_total expected %0d, got %0d",
                             $time, want.vertex_total, o_out_data.vertex_total);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_max = 6;
        test_single_vertex();
        test_closed_shapes();
        test_keep_threshold();
        test_long_polygon();
        test_random_polygons();

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Even with every vertex closing a polygon behind the longest sender gaps and
    // receiver stalls, a correct run ends well before this timeout.
    initial begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/ppf_pkg.sv
sv/ppf_dp.sv
sv/ppf_ctrl.sv
sv/polygon_perimeter_filter_top.sv
tb/tb_polygon_perimeter_filter_top.sv
